FILE: hdl/ufms_pkg.sv
// shared constants and types for the union-find move-sum store
`default_nettype none
package ufms_pkg;

  localparam int ID_W  = 9;
  localparam int SUM_W = 16;
  localparam int CNT_W = 9;

  // operation codes on the kind field
  localparam logic [1:0] KIND_UNION   = 2'd0;
  localparam logic [1:0] KIND_MOVE    = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;
  localparam logic [1:0] KIND_RESTART = 2'd3;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e            op;
    logic [SUM_W-1:0]   sum_a;
    logic [SUM_W-1:0]   sum_b;
    logic [CNT_W-1:0]   cnt_a;
    logic [CNT_W-1:0]   cnt_b;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]   cnt;
  } alu_rsp_t;

endpackage
`default_nettype wire

FILE: hdl/ufms_alu.sv
// shared add/subtract unit for set sums and member counts
`default_nettype none
module ufms_alu (
  input  ufms_pkg::alu_req_t req_i,
  output ufms_pkg::alu_rsp_t rsp_o
);

  always_comb begin
    case (req_i.op)
      ufms_pkg::ALU_SUB: begin
        rsp_o.sum = req_i.sum_a - req_i.sum_b;
        rsp_o.cnt = req_i.cnt_a - req_i.cnt_b;
      end
      default: begin
        rsp_o.sum = req_i.sum_a + req_i.sum_b;
        rsp_o.cnt = req_i.cnt_a + req_i.cnt_b;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/ufms_store.sv
// element link and set node memories, one write and one registered read each
`default_nettype none
module ufms_store #(
  parameter  int Depth = 256,
  localparam int AW    = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       link_we_i,
  input  logic [AW-1:0]              link_waddr_i,
  input  logic [AW-1:0]              link_wdata_i,
  input  logic [AW-1:0]              link_raddr_i,
  output logic [AW-1:0]              link_rdata_o,
  input  logic                       node_we_i,
  input  logic [AW-1:0]              node_waddr_i,
  input  logic [AW-1:0]              node_wparent_i,
  input  logic [ufms_pkg::SUM_W-1:0] node_wsum_i,
  input  logic [ufms_pkg::CNT_W-1:0] node_wcnt_i,
  input  logic [AW-1:0]              node_raddr_i,
  output logic [AW-1:0]              node_rparent_o,
  output logic [ufms_pkg::SUM_W-1:0] node_rsum_o,
  output logic [ufms_pkg::CNT_W-1:0] node_rcnt_o
);

  logic [AW-1:0]              link_mem [Depth];
  logic [AW-1:0]              par_mem  [Depth];
  logic [ufms_pkg::SUM_W-1:0] sum_mem  [Depth];
  logic [ufms_pkg::CNT_W-1:0] cnt_mem  [Depth];

  logic [AW-1:0]              link_rd_q;
  logic [AW-1:0]              par_rd_q;
  logic [ufms_pkg::SUM_W-1:0] sum_rd_q;
  logic [ufms_pkg::CNT_W-1:0] cnt_rd_q;

  always_ff @(posedge clk_i) begin
    if (link_we_i) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    link_rd_q <= link_mem[link_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (node_we_i) begin
      par_mem[node_waddr_i] <= node_wparent_i;
      sum_mem[node_waddr_i] <= node_wsum_i;
      cnt_mem[node_waddr_i] <= node_wcnt_i;
    end
    par_rd_q <= par_mem[node_raddr_i];
    sum_rd_q <= sum_mem[node_raddr_i];
    cnt_rd_q <= cnt_mem[node_raddr_i];
  end

  assign link_rdata_o   = link_rd_q;
  assign node_rparent_o = par_rd_q;
  assign node_rsum_o    = sum_rd_q;
  assign node_rcnt_o    = cnt_rd_q;

endmodule
`default_nettype wire

FILE: hdl/union_find_move_sum.sv
// top level: disjoint-set store with union, move, query and restart under a small sequencer
// a query reads the link, walks parent hops to the root and registers the root's totals as its result
// union and move find both roots, then rewrite a's root and b's root; they give no result
// restart sweeps all MAX_ELEMENTS entries; a union, move or query with an out-of-use id is dropped
// one item at a time; the parent walk reads one node per cycle from the node memory
// reset: element_count = 256, then a clearing sweep over all MAX_ELEMENTS entries with input stalled
`default_nettype none
module union_find_move_sum #(
  parameter int MAX_ELEMENTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [8:0]  elem_a_i,
  input  logic [8:0]  elem_b_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [8:0]  set_count_o,
  output logic [15:0] set_sum_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NW = $clog2(MAX_ELEMENTS);

  // sequencer state codes
  localparam logic [3:0] S_CLEAR  = 4'd0;  // clearing sweep over the store
  localparam logic [3:0] S_IDLE   = 4'd1;  // ready for a beat
  localparam logic [3:0] S_LINK   = 4'd2;  // issue element link read
  localparam logic [3:0] S_LOOK   = 4'd3;  // link data back, issue first node read
  localparam logic [3:0] S_WALK   = 4'd4;  // one parent hop per cycle
  localparam logic [3:0] S_QUERY  = 4'd5;  // hand the result to the output register
  localparam logic [3:0] S_UPD_RA = 4'd6;  // rewrite root of a's set
  localparam logic [3:0] S_UPD_RB = 4'd7;  // rewrite root of b's set (and link on move)

  logic [3:0]                 state_q, state_d;
  logic [8:0]                 elem_count_q, elem_count_d;
  logic [1:0]                 kind_q, kind_d;
  logic [8:0]                 a_q, a_d;
  logic [8:0]                 b_q, b_d;
  logic                       phase_q, phase_d;  // 0 finds a's root, 1 finds b's root
  logic [NW-1:0]              cur_q, cur_d;
  logic [NW-1:0]              clr_idx_q, clr_idx_d;
  logic [NW-1:0]              ra_q, ra_d;
  logic [NW-1:0]              rb_q, rb_d;
  logic [15:0]                ra_sum_q, ra_sum_d;
  logic [15:0]                rb_sum_q, rb_sum_d;
  logic [8:0]                 ra_cnt_q, ra_cnt_d;
  logic [8:0]                 rb_cnt_q, rb_cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic [8:0]                 set_count_q, set_count_d;
  logic [15:0]                set_sum_q, set_sum_d;

  // store ports
  logic                       link_we;
  logic [NW-1:0]              link_waddr;
  logic [NW-1:0]              link_wdata;
  logic [NW-1:0]              link_raddr;
  logic [NW-1:0]              link_rd;
  logic                       node_we;
  logic [NW-1:0]              node_waddr;
  logic [NW-1:0]              node_wparent;
  logic [NW-1:0]              node_raddr;
  logic [NW-1:0]              node_par_rd;
  logic [15:0]                node_sum_rd;
  logic [8:0]                 node_cnt_rd;

  ufms_pkg::alu_req_t         alu_req;
  ufms_pkg::alu_rsp_t         alu_rsp;

  logic                       in_accept;
  logic                       a_ok;
  logic                       b_ok;
  logic                       is_root;
  logic [8:0]                 elem_sel;
  logic [NW-1:0]              a_idx;
  logic [15:0]                a_ext;
  logic                       cfg_write;

  // configuration register: one word, selected whenever paddr[2] is low; other offsets read zero and ignore writes
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == 1'b0) ? 32'(elem_count_q) : 32'd0;

  // id in use: nonzero, within element_count and within the store
  assign a_ok = (elem_a_i != 9'd0) && (elem_a_i <= elem_count_q) &&
                (32'(elem_a_i) <= MAX_ELEMENTS);
  assign b_ok = (elem_b_i != 9'd0) && (elem_b_i <= elem_count_q) &&
                (32'(elem_b_i) <= MAX_ELEMENTS);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign elem_sel   = phase_q ? b_q : a_q;
  assign link_raddr = NW'(elem_sel - 9'd1);
  assign a_idx      = NW'(a_q - 9'd1);
  assign a_ext      = 16'(a_q);

  // in S_LOOK the first node of the chain comes from the link, afterwards from the parent
  assign node_raddr = (state_q == S_LOOK) ? link_rd : node_par_rd;
  assign is_root    = (node_par_rd == cur_q);

  ufms_store #(
    .Depth(MAX_ELEMENTS)
  ) u_store (
    .clk_i          (clk_i),
    .link_we_i      (link_we),
    .link_waddr_i   (link_waddr),
    .link_wdata_i   (link_wdata),
    .link_raddr_i   (link_raddr),
    .link_rdata_o   (link_rd),
    .node_we_i      (node_we),
    .node_waddr_i   (node_waddr),
    .node_wparent_i (node_wparent),
    .node_wsum_i    (alu_rsp.sum),
    .node_wcnt_i    (alu_rsp.cnt),
    .node_raddr_i   (node_raddr),
    .node_rparent_o (node_par_rd),
    .node_rsum_o    (node_sum_rd),
    .node_rcnt_o    (node_cnt_rd)
  );

  // every node write takes its sum and count through the one shared unit
  ufms_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  always_comb begin
    state_d      = state_q;
    elem_count_d = cfg_write ? pwdata[8:0] : elem_count_q;
    kind_d       = kind_q;
    a_d          = a_q;
    b_d          = b_q;
    phase_d      = phase_q;
    cur_d        = cur_q;
    clr_idx_d    = clr_idx_q;
    ra_d         = ra_q;
    rb_d         = rb_q;
    ra_sum_d     = ra_sum_q;
    rb_sum_d     = rb_sum_q;
    ra_cnt_d     = ra_cnt_q;
    rb_cnt_d     = rb_cnt_q;
    set_count_d  = set_count_q;
    set_sum_d    = set_sum_q;
    // a waiting result leaves once the far side takes it
    out_valid_d  = out_valid_q && out_stall_i;

    link_we      = 1'b0;
    link_waddr   = clr_idx_q;
    link_wdata   = clr_idx_q;
    node_we      = 1'b0;
    node_waddr   = clr_idx_q;
    node_wparent = clr_idx_q;

    alu_req.op    = ufms_pkg::ALU_ADD;
    alu_req.sum_a = 16'd0;
    alu_req.sum_b = 16'd0;
    alu_req.cnt_a = 9'd0;
    alu_req.cnt_b = 9'd0;

    case (state_q)
      S_CLEAR: begin
        // singleton entry: link i, parent i, sum i+1, count 1
        link_we       = 1'b1;
        node_we       = 1'b1;
        alu_req.sum_a = 16'(clr_idx_q);
        alu_req.sum_b = 16'd1;
        alu_req.cnt_b = 9'd1;
        clr_idx_d     = clr_idx_q + NW'(1);
        if (clr_idx_q == NW'(MAX_ELEMENTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          kind_d  = kind_i;
          a_d     = elem_a_i;
          b_d     = elem_b_i;
          phase_d = 1'b0;
          case (kind_i)
            ufms_pkg::KIND_RESTART: begin
              clr_idx_d = '0;
              state_d   = S_CLEAR;
            end
            ufms_pkg::KIND_QUERY: begin
              state_d = a_ok ? S_LINK : S_IDLE;
            end
            default: begin
              state_d = (a_ok && b_ok) ? S_LINK : S_IDLE;
            end
          endcase
        end
      end
      S_LINK: begin
        state_d = S_LOOK;
      end
      S_LOOK: begin
        cur_d   = link_rd;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (is_root) begin
          if (!phase_q) begin
            ra_d     = cur_q;
            ra_sum_d = node_sum_rd;
            ra_cnt_d = node_cnt_rd;
            if (kind_q == ufms_pkg::KIND_QUERY) begin
              state_d = S_QUERY;
            end else begin
              phase_d = 1'b1;
              state_d = S_LINK;
            end
          end else begin
            rb_d     = cur_q;
            rb_sum_d = node_sum_rd;
            rb_cnt_d = node_cnt_rd;
            // already one set: nothing to do
            state_d  = (cur_q == ra_q) ? S_IDLE : S_UPD_RA;
          end
        end else begin
          cur_d = node_par_rd;
        end
      end
      S_QUERY: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          set_count_d = ra_cnt_q;
          set_sum_d   = ra_sum_q;
          state_d     = S_IDLE;
        end
      end
      S_UPD_RA: begin
        node_we      = 1'b1;
        node_waddr   = ra_q;
        node_wparent = ra_q;
        alu_req.sum_a = ra_sum_q;
        alu_req.cnt_a = ra_cnt_q;
        if (kind_q == ufms_pkg::KIND_UNION) begin
          // a's root absorbs b's set
          alu_req.sum_b = rb_sum_q;
          alu_req.cnt_b = rb_cnt_q;
        end else begin
          // a leaves its old set
          alu_req.op    = ufms_pkg::ALU_SUB;
          alu_req.sum_b = a_ext;
          alu_req.cnt_b = 9'd1;
        end
        state_d = S_UPD_RB;
      end
      S_UPD_RB: begin
        node_we       = 1'b1;
        node_waddr    = rb_q;
        alu_req.sum_a = rb_sum_q;
        alu_req.cnt_a = rb_cnt_q;
        if (kind_q == ufms_pkg::KIND_UNION) begin
          // b's root hangs under a's root, its totals pass through unchanged
          node_wparent = ra_q;
        end else begin
          // a joins b's set and links straight to its root
          node_wparent  = rb_q;
          alu_req.sum_b = a_ext;
          alu_req.cnt_b = 9'd1;
          link_we       = 1'b1;
          link_waddr    = a_idx;
          link_wdata    = rb_q;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_idx_q    <= '0;
      elem_count_q <= 9'd256;
      phase_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_idx_q    <= clr_idx_d;
      elem_count_q <= elem_count_d;
      phase_q      <= phase_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    a_q         <= a_d;
    b_q         <= b_d;
    cur_q       <= cur_d;
    ra_q        <= ra_d;
    rb_q        <= rb_d;
    ra_sum_q    <= ra_sum_d;
    rb_sum_q    <= rb_sum_d;
    ra_cnt_q    <= ra_cnt_d;
    rb_cnt_q    <= rb_cnt_d;
    set_count_q <= set_count_d;
    set_sum_q   <= set_sum_d;
  end

  assign out_valid_o = out_valid_q;
  assign set_count_o = set_count_q;
  assign set_sum_o   = set_sum_q;

  // a result only ever comes out of the query step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_QUERY)
    else $error("result raised outside the query step");

  // the second find never runs for a query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && phase_q) |-> kind_q != ufms_pkg::KIND_QUERY)
    else $error("second find started for a query");

  // root updates only happen for two distinct roots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD_RA) |-> ra_q != rb_q)
    else $error("root update with a and b in one set");

  // the store is never written while a find is walking it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK || state_q == S_LOOK) |-> !node_we && !link_we)
    else $error("store written during a find");

endmodule
`default_nettype wire

FILE: sim/ufms_checker.sv
// checker for the union-find move-sum store: tracks the sets, predicts query results, compares
module ufms_checker #(
  parameter int         NODES   = 256,
  parameter logic [2:0] EC_ADDR = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [8:0]  elem_a_i,
  input  logic [8:0]  elem_b_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [8:0]  set_count_i,
  input  logic [15:0] set_sum_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NODE_W      = $clog2(NODES);
  localparam int unsigned EC_RESET    = 256;

  typedef struct packed {
    logic [ufms_pkg::CNT_W-1:0] members;
    logic [ufms_pkg::SUM_W-1:0] id_sum;
  } set_stats_t;

  int unsigned       elem_limit = EC_RESET;
  logic [NODE_W-1:0] link_of   [NODES];
  logic [NODE_W-1:0] parent_of [NODES];
  int unsigned       sum_at    [NODES];
  int unsigned       cnt_at    [NODES];
  set_stats_t        query_stats_due [$];
  int                fails   = 0;

  task automatic clear_store();
    for (int i = 0; i < NODES; i++) begin
      link_of[i]   = NODE_W'(i);
      parent_of[i] = NODE_W'(i);
      sum_at[i]    = i + 1;
      cnt_at[i]    = 1;
    end
  endtask

  // bounded walk up the parent links
  function automatic logic [NODE_W-1:0] root_of_node(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] cur;
    int                steps;
    cur   = node;
    steps = 0;
    while (parent_of[cur] != cur && steps < NODES) begin
      cur = parent_of[cur];
      steps++;
    end
    return cur;
  endfunction

  function automatic bit id_live(input logic [ufms_pkg::ID_W-1:0] id);
    return id >= 1 && id <= elem_limit && id <= NODES;
  endfunction

  task automatic predict_set_op(input logic [1:0] op, input logic [ufms_pkg::ID_W-1:0] a,
                                input logic [ufms_pkg::ID_W-1:0] b);
    logic [NODE_W-1:0] ra;
    logic [NODE_W-1:0] rb;
    set_stats_t        st;
    if (op == ufms_pkg::KIND_RESTART) begin
      clear_store();
      return;
    end
    if (op == ufms_pkg::KIND_QUERY) begin
      if (!id_live(a)) return;
      ra         = root_of_node(link_of[a - 1]);
      st.members = ufms_pkg::CNT_W'(cnt_at[ra]);
      st.id_sum  = ufms_pkg::SUM_W'(sum_at[ra]);
      query_stats_due.push_back(st);
      return;
    end
    if (!id_live(a) || !id_live(b)) return;
    ra = root_of_node(link_of[a - 1]);
    rb = root_of_node(link_of[b - 1]);
    if (ra == rb) return;
    if (op == ufms_pkg::KIND_UNION) begin
      parent_of[rb] = ra;
      sum_at[ra]   += sum_at[rb];
      cnt_at[ra]   += cnt_at[rb];
    end else begin
      link_of[a - 1] = rb;
      sum_at[rb]    += a;
      sum_at[ra]    -= a;
      cnt_at[rb]    += 1;
      cnt_at[ra]    -= 1;
    end
  endtask

  task automatic report(input string what, input int want, input int got);
    fails++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  task automatic check_result(input logic [ufms_pkg::CNT_W-1:0] members,
                              input logic [ufms_pkg::SUM_W-1:0] id_sum);
    set_stats_t want;
    if (query_stats_due.size() == 0) begin
      report("unexpected result beat, set_count", -1, members);
      return;
    end
    want = query_stats_due.pop_front();
    if (want.members !== members) report("set_count", want.members, members);
    if (want.id_sum !== id_sum) report("set_sum", want.id_sum, id_sum);
  endtask

  // results are checked before the same edge's input beat is folded in
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_limit = EC_RESET;
      clear_store();
      query_stats_due.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == EC_ADDR)
        elem_limit = pwdata_i[ufms_pkg::ID_W-1:0];
      if (out_valid_i && !out_stall_i) check_result(set_count_i, set_sum_i);
      if (in_valid_i && !in_stall_i) predict_set_op(kind_i, elem_a_i, elem_b_i);
    end
    fail_count_o <= fails;
    pending_o    <= query_stats_due.size();
  end

endmodule

FILE: sim/tb_top.sv
// testbench top: drives the union-find move-sum store and gives the verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         MAX_ELEMENTS       = 256;
  localparam int         CLK_PERIOD         = 4;
  localparam int         RESET_CYCLES       = 9;
  // longest quiet stretch: union/move with two full-depth walks, or a restart sweep
  localparam int         SETTLE_CYCLES      = 600;
  localparam int         CYCLE_LIMIT        = 3_000_000;
  // one long receiver hold-off, started once this many input beats have gone in
  localparam int         HOLD_AT            = 700;
  localparam int         HOLD_CYCLES        = 800;
  localparam logic [2:0] ADDR_ELEMENT_COUNT = 3'd0;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [1:0]  kind      = ufms_pkg::KIND_QUERY;
  logic [8:0]  elem_a    = '0;
  logic [8:0]  elem_b    = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [8:0]  set_count;
  logic [15:0] set_sum;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int          fails;
  int          pending;
  int unsigned ec_now     = 256;  // element_count as last written (reset value to start)
  int          beats_in   = 0;    // accepted input beats, all kinds
  int          burst_left = 0;
  int          cycles     = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  union_find_move_sum #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .kind_i     (kind),
    .elem_a_i   (elem_a),
    .elem_b_i   (elem_b),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .set_count_o(set_count),
    .set_sum_o  (set_sum),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  ufms_checker #(
    .NODES  (MAX_ELEMENTS),
    .EC_ADDR(ADDR_ELEMENT_COUNT)
  ) set_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .kind_i      (kind),
    .elem_a_i    (elem_a),
    .elem_b_i    (elem_b),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .set_count_i (set_count),
    .set_sum_i   (set_sum),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .fail_count_o(fails),
    .pending_o   (pending)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ids 1..element_count are live; anything else makes the block drop a union, move or query beat
  function automatic bit id_live(input logic [8:0] id);
    return id >= 1 && id <= ec_now;
  endfunction

  // mostly live ids, now and then any 9-bit value (0, out of range, top bit set)
  function automatic logic [8:0] pick_id();
    if ($urandom_range(0, 99) < 8) return 9'($urandom_range(0, 511));
    return 9'($urandom_range(1, ec_now));
  endfunction

  // one input beat; valid is raised at a falling edge and held until the block takes it.
  // the sender runs in bursts: between bursts valid drops for a random gap, sometimes none
  task automatic offer(input logic [1:0] op, input logic [8:0] a, input logic [8:0] b,
                       inout int done);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    kind     <= op;
    elem_a   <= a;
    elem_b   <= b;
    do @(posedge clk_i); while (in_stall);
    beats_in++;
    // ignored beats do not count toward the phase's share
    if (op == ufms_pkg::KIND_RESTART ||
        (id_live(a) && (op == ufms_pkg::KIND_QUERY || id_live(b)))) done++;
    @(negedge clk_i);
  endtask

  // setup cycle, then access cycle; the write lands on the edge with penable and pready high
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // every query answered, then room for a union/move or restart that makes no result
  task automatic wait_idle();
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // random traffic: mostly unions and moves on live ids so that sets grow and trees get deep,
  // with chain-building runs that stack roots one above another, plus queries, restarts and noise
  task automatic random_items(input int n);
    int          done;
    int          r;
    int          len;
    int          s;
    int unsigned top_len;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 12 && ec_now >= 4) begin
        // union(k+1, k) puts the old root under a new one each time: one hop deeper per beat
        top_len = (ec_now - 1 < 48) ? ec_now - 1 : 48;
        len     = $urandom_range(3, top_len);
        s       = $urandom_range(1, ec_now - len);
        for (int j = 0; j < len; j++)
          offer(ufms_pkg::KIND_UNION, 9'(s + j + 1), 9'(s + j), done);
        offer(ufms_pkg::KIND_QUERY, 9'(s), 9'($urandom_range(0, 511)), done);
        offer(ufms_pkg::KIND_MOVE, 9'(s), pick_id(), done);
        offer(ufms_pkg::KIND_QUERY, 9'(s + len), 9'($urandom_range(0, 511)), done);
      end else if (r < 13) begin
        offer(ufms_pkg::KIND_RESTART, 9'($urandom_range(0, 511)),
              9'($urandom_range(0, 511)), done);
      end else if (r < 50) begin
        offer(ufms_pkg::KIND_UNION, pick_id(), pick_id(), done);
      end else if (r < 72) begin
        offer(ufms_pkg::KIND_MOVE, pick_id(), pick_id(), done);
      end else begin
        offer(ufms_pkg::KIND_QUERY, pick_id(), 9'($urandom_range(0, 511)), done);
      end
    end
    in_valid <= 1'b0;
  endtask

  // a phase: wait for quiet, set element_count, then random traffic
  task automatic run_phase(input int unsigned ec, input int n);
    wait_idle();
    write_reg(ADDR_ELEMENT_COUNT, 32'(ec));
    ec_now = ec;
    random_items(n);
  endtask

  // receiver: stall patterns in segments (never, light, heavy, nearly always),
  // and once a long hold-off so that the block backs up and stalls its input
  initial begin
    int  seg;
    int  mode;
    int  pct;
    bit  held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(10, 150);
      case (mode)
        0:       pct = 0;
        1:       pct = 30;
        2:       pct = 60;
        default: pct = 90;
      endcase
      repeat (seg) begin
        @(negedge clk_i);
        if (!held && beats_in >= HOLD_AT) begin
          held = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk_i);
        end else begin
          out_stall <= ($urandom_range(0, 99) < pct);
        end
      end
    end
  end

  // main stimulus
  initial begin
    int dir_cnt;
    dir_cnt = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset element_count of 256
    offer(ufms_pkg::KIND_QUERY, 9'd1, 9'd0, dir_cnt);        // lowest id, singleton
    offer(ufms_pkg::KIND_QUERY, 9'd256, 9'd511, dir_cnt);    // highest id
    offer(ufms_pkg::KIND_QUERY, 9'd0, 9'd1, dir_cnt);        // id zero is dropped
    offer(ufms_pkg::KIND_QUERY, 9'd257, 9'd1, dir_cnt);      // just past the store
    offer(ufms_pkg::KIND_QUERY, 9'd511, 9'd1, dir_cnt);      // all ones
    offer(ufms_pkg::KIND_UNION, 9'd1, 9'd256, dir_cnt);
    offer(ufms_pkg::KIND_QUERY, 9'd256, 9'd0, dir_cnt);
    offer(ufms_pkg::KIND_UNION, 9'd256, 9'd1, dir_cnt);      // already one set
    offer(ufms_pkg::KIND_UNION, 9'd0, 9'd5, dir_cnt);        // bad first id
    offer(ufms_pkg::KIND_UNION, 9'd5, 9'd511, dir_cnt);      // bad second id
    offer(ufms_pkg::KIND_MOVE, 9'd511, 9'd5, dir_cnt);
    offer(ufms_pkg::KIND_MOVE, 9'd256, 9'd5, dir_cnt);
    offer(ufms_pkg::KIND_QUERY, 9'd5, 9'd0, dir_cnt);
    offer(ufms_pkg::KIND_QUERY, 9'd1, 9'd0, dir_cnt);
    offer(ufms_pkg::KIND_MOVE, 9'd1, 9'd5, dir_cnt);         // old root left with no members
    offer(ufms_pkg::KIND_QUERY, 9'd1, 9'd0, dir_cnt);
    offer(ufms_pkg::KIND_MOVE, 9'd5, 9'd1, dir_cnt);         // move within one set
    offer(ufms_pkg::KIND_UNION, 9'd3, 9'd4, dir_cnt);
    offer(ufms_pkg::KIND_UNION, 9'd2, 9'd3, dir_cnt);
    offer(ufms_pkg::KIND_QUERY, 9'd4, 9'd0, dir_cnt);
    offer(ufms_pkg::KIND_UNION, 9'd5, 9'd2, dir_cnt);
    offer(ufms_pkg::KIND_QUERY, 9'd3, 9'd0, dir_cnt);
    offer(ufms_pkg::KIND_RESTART, 9'd511, 9'd0, dir_cnt);    // ids ignored on restart
    offer(ufms_pkg::KIND_QUERY, 9'd256, 9'd0, dir_cnt);
    offer(ufms_pkg::KIND_MOVE, 9'd2, 9'd3, dir_cnt);
    offer(ufms_pkg::KIND_QUERY, 9'd2, 9'd0, dir_cnt);
    in_valid <= 1'b0;

    // element_count from its minimum up to the full store, with one random setting
    run_phase(1, 60);
    run_phase(2, 80);
    run_phase(17, 250);
    run_phase(256, 500);
    run_phase(255, 250);
    run_phase($urandom_range(3, 128), 250);
    run_phase(256, 260);

    wait_idle();
    if (fails == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
